### rtl/phase_distortion_oscillator_macros.svh
// ============================================================================
// Phase distortion oscillator assertion macros
// Shared concurrent assertion forms, compiled out when ASSERT_OFF is set.
// ============================================================================
`ifndef PHASE_DISTORTION_OSCILLATOR_MACROS_SVH
`define PHASE_DISTORTION_OSCILLATOR_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define PDO_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("phase distortion oscillator assertion failed");
// Next-cycle implication.
`define PDO_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("phase distortion oscillator assertion failed");
`else
`define PDO_ASSERT_IMP(label, clk, rst, ante, cons)
`define PDO_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/pdo_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Phase distortion oscillator package
// Shared constants, register indexes, wave codes and interface structs.
// ============================================================================
package pdo_pkg;

  localparam int ADDR_BITS = 5;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_PHASE_STEP  = 3'd0;
  localparam logic [2:0] REG_AMOUNT      = 3'd1;
  localparam logic [2:0] REG_FIRST_WAVE  = 3'd2;
  localparam logic [2:0] REG_SECOND_WAVE = 3'd3;
  localparam logic [2:0] REG_ALT_ENABLE  = 3'd4;
  localparam logic [2:0] REG_OS_SHIFT    = 3'd5;

  // Wave codes.
  localparam logic [3:0] WAVE_SAW      = 4'd0;
  localparam logic [3:0] WAVE_SAWPULSE = 4'd1;
  localparam logic [3:0] WAVE_SQUARE   = 4'd2;
  localparam logic [3:0] WAVE_PULSE    = 4'd3;
  localparam logic [3:0] WAVE_DSINE    = 4'd4;
  localparam logic [3:0] WAVE_RES_SAW  = 4'd5;
  localparam logic [3:0] WAVE_RES_TRI  = 4'd6;
  localparam logic [3:0] WAVE_RES_TRAP = 4'd7;

  localparam logic [16:0] AMOUNT_ONE = 17'd65536;
  localparam logic [31:0] K049       = 32'd2104533975;
  localparam logic [31:0] K090       = 32'd3865470566;

  // (2^33 + 1) / 3: x * RECIP3 >> 33 is floor(x / 3) for x up to 2^32.
  localparam logic [31:0] RECIP3     = 32'hAAAA_AAAB;

  // Odd Taylor coefficients of sin(pi/2*r), Q30, innermost first.
  localparam logic [30:0] SIN_C0 = 31'd172272;
  localparam logic [30:0] SIN_C1 = 31'd5026995;
  localparam logic [30:0] SIN_C2 = 31'd85569306;
  localparam logic [30:0] SIN_C3 = 31'd693598668;
  localparam logic [30:0] SIN_C4 = 31'd1686629713;

  typedef struct packed {
    logic [31:0] phase;
    logic [16:0] amt;
    logic [3:0]  wave;
  } job_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

endpackage

### rtl/pdo_mul.sv
`timescale 1ns / 1ps
// ============================================================================
// Shared multiplier
// Unsigned 33 by 33 bit multiplier with a registered product.
// ============================================================================
module pdo_mul (
  input  logic        clk,
  input  logic [32:0] a,
  input  logic [32:0] b,
  output logic [65:0] prod
);

  always_ff @(posedge clk) begin
    prod <= 66'(a) * 66'(b);
  end

endmodule

### rtl/pdo_div.sv
`timescale 1ns / 1ps
// ============================================================================
// Iterative divider
// Restoring division of a 64-bit dividend by a 33-bit divisor, one bit a cycle.
// ============================================================================
module pdo_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [32:0] den,
  output logic        done,
  output logic [63:0] quot
);

  logic        busy;
  logic [5:0]  cnt;
  logic [32:0] rem;
  logic [32:0] dreg;
  logic [33:0] rem_sh;
  logic [33:0] rem_next;
  logic        qbit;

  always_comb begin
    rem_sh   = {rem, quot[63]};
    qbit     = (rem_sh >= {1'b0, dreg});
    rem_next = qbit ? (rem_sh - {1'b0, dreg}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      rem  <= '0;
      dreg <= den;
    end else if (busy) begin
      quot <= {quot[62:0], qbit};
      rem  <= rem_next[32:0];
    end
  end

endmodule

### rtl/pdo_seq.sv
`timescale 1ns / 1ps
// ============================================================================
// Oscillator sequencer
// Steps one sample through the wave remap, sine and window on shared units.
// ============================================================================
module pdo_seq #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  pdo_pkg::job_t                 job,
  input  logic                          take,
  output pdo_pkg::seq_stat_t            stat,
  output logic signed [SAMPLE_BITS-1:0] sample
);
  import pdo_pkg::*;

  localparam int SH = 31 - SAMPLE_BITS;

  typedef enum logic [23:0] {
    S_IDLE     = 24'h000001,
    S_DISPATCH = 24'h000002,
    S_M_KNEE   = 24'h000004,
    S_KNEE     = 24'h000008,
    S_M_HF     = 24'h000010,
    S_W3       = 24'h000020,
    S_W3_W     = 24'h000040,
    S_SQ_SEL   = 24'h000080,
    S_PU_SEL   = 24'h000100,
    S_PU_MUL   = 24'h000200,
    S_DIV_W    = 24'h000400,
    S_W4_WIN   = 24'h000800,
    S_M_PK     = 24'h001000,
    S_WMUL     = 24'h002000,
    S_WMUL2    = 24'h004000,
    S_SIN0     = 24'h008000,
    S_SIN1     = 24'h010000,
    S_SIN2     = 24'h020000,
    S_SIN3     = 24'h040000,
    S_SIN4     = 24'h080000,
    S_SIN5     = 24'h100000,
    S_SIN6     = 24'h200000,
    S_FINAL    = 24'h400000,
    S_DONE     = 24'h800000
  } state_t;

  state_t state, state_next, ret;

  logic [31:0]        p;
  logic [16:0]        a;
  logic [3:0]         wave;
  logic [31:0]        m;
  logic [31:0]        hf;
  logic [31:0]        w;
  logic [33:0]        g;
  logic [33:0]        kbase;
  logic               knee2;
  logic [31:0]        sin_turn;
  logic [30:0]        sr;
  logic [30:0]        sr2;
  logic [1:0]         squad;
  logic [30:0]        winr;
  logic signed [31:0] y;

  logic [32:0] mul_a, mul_b;
  logic [65:0] prod;
  logic        div_start, div_done;
  logic [63:0] div_num, quot;
  logic [32:0] div_den;
  logic [33:0] kbase_c;
  logic [31:0] turn_c;

  logic [31:0] x_k;
  logic        knee_lo;
  logic [33:0] p34, s_wh, s_2wh, s_2w2h;
  logic [32:0] s_whf;
  logic [32:0] negp;
  logic [30:0] win57;
  logic [19:0] kf;
  logic [30:0] sr_c;
  logic [30:0] pq30;
  logic [31:0] pq16;
  logic [30:0] h_c;
  logic [30:0] h_end;
  logic [30:0] ymag;
  logic [32:0] win4;
  logic [31:0] rnd, rsh, sat;
  logic [31:0] lim;

  pdo_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  pdo_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(quot)
  );

  always_comb begin
    x_k     = g[31:0];
    knee_lo = (x_k < m);
    p34     = {2'b0, p};
    s_wh    = 34'(w) + 34'(hf[31:1]);
    s_2wh   = 34'(w) + s_wh;
    s_2w2h  = s_2wh + 34'(hf[31:1]);
    s_whf   = 33'(w) + 33'(hf);
    negp    = 33'h1_0000_0000 - {1'b0, p};
    kf      = (wave == WAVE_DSINE) ? (20'(AMOUNT_ONE) + 20'(a))
                                   : (20'(AMOUNT_ONE) + 20'({a, 3'b000}) - 20'(a));
    case (wave)
      WAVE_RES_SAW: win57 = negp[32:2];
      WAVE_RES_TRI: win57 = p[31] ? negp[31:1] : p[31:1];
      default: begin
        if (p < 32'h4000_0000) begin
          win57 = p[30:0];
        end else if (p > 32'hC000_0000) begin
          win57 = negp[30:0];
        end else begin
          win57 = 31'h4000_0000;
        end
      end
    endcase
    sr_c  = sin_turn[30] ? (31'h4000_0000 - {1'b0, sin_turn[29:0]})
                         : {1'b0, sin_turn[29:0]};
    pq30  = prod[60:30];
    pq16  = prod[47:16];
    h_end = (pq30 > 31'h4000_0000) ? 31'h4000_0000 : pq30;
    ymag  = y[31] ? 31'(-y) : 31'(y);
    win4  = 33'sh0_4000_0000 - 33'(y);
    lim   = (32'd1 << (SAMPLE_BITS - 1)) - 32'd1;
    rnd   = 32'(ymag) + (32'd1 << (SH - 1));
    rsh   = rnd >> SH;
    sat   = (rsh > lim) ? lim : rsh;
    case (state)
      S_SIN2:  h_c = SIN_C1 - pq30;
      S_SIN3:  h_c = SIN_C2 - pq30;
      S_SIN4:  h_c = SIN_C3 - pq30;
      default: h_c = SIN_C4 - pq30;
    endcase
  end

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    kbase_c    = '0;
    turn_c     = 32'h4000_0000;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (wave)
          WAVE_SAW, WAVE_SAWPULSE: begin
            mul_a = 33'(K049);
            mul_b = 33'(a);
            state_next = S_M_KNEE;
          end
          WAVE_SQUARE, WAVE_PULSE: begin
            mul_a = 33'(K090);
            mul_b = 33'(a);
            state_next = S_M_HF;
          end
          WAVE_RES_SAW, WAVE_RES_TRI, WAVE_RES_TRAP: begin
            mul_a = 33'(p);
            mul_b = 33'(kf);
            state_next = S_M_PK;
          end
          default: state_next = S_SIN0;
        endcase
      end
      S_M_KNEE: state_next = S_KNEE;
      S_KNEE: begin
        div_start = 1'b1;
        if (knee_lo) begin
          div_num = {1'b0, x_k, 31'b0};
          div_den = {1'b0, m};
          kbase_c = '0;
        end else begin
          div_num = {1'b0, x_k - m, 31'b0};
          div_den = 33'h1_0000_0000 - {1'b0, m};
          kbase_c = 34'h0_8000_0000;
        end
        state_next = S_DIV_W;
      end
      S_M_HF: state_next = S_W3;
      // One third of the ramp span by reciprocal multiplication.
      S_W3: begin
        mul_a      = 33'h1_0000_0000 - {1'b0, hf};
        mul_b      = 33'(RECIP3);
        state_next = S_W3_W;
      end
      S_W3_W: begin
        state_next = (wave == WAVE_SQUARE) ? S_SQ_SEL : S_PU_SEL;
      end
      S_SQ_SEL: begin
        if (p < w) begin
          div_start  = 1'b1;
          div_num    = {2'b0, p, 30'b0};
          div_den    = {1'b0, w};
          kbase_c    = '0;
          state_next = S_DIV_W;
        end else if (p34 < s_wh) begin
          turn_c     = 32'h4000_0000;
          state_next = S_SIN0;
        end else if (p34 < s_2wh) begin
          div_start  = 1'b1;
          div_num    = {1'b0, 32'(p34 - s_wh), 31'b0};
          div_den    = {1'b0, w};
          kbase_c    = 34'h0_4000_0000;
          state_next = S_DIV_W;
        end else if (p34 < s_2w2h) begin
          turn_c     = 32'hC000_0000;
          state_next = S_SIN0;
        end else begin
          div_start  = 1'b1;
          div_num    = {2'b0, 32'(p34 - s_2w2h), 30'b0};
          div_den    = {1'b0, w};
          kbase_c    = 34'h0_C000_0000;
          state_next = S_DIV_W;
        end
      end
      S_PU_SEL: begin
        if (p < w) begin
          div_start  = 1'b1;
          div_num    = {2'b0, p, 30'b0};
          div_den    = {1'b0, w};
          kbase_c    = '0;
          state_next = S_DIV_W;
        end else if (p34 < 34'(s_whf)) begin
          turn_c     = 32'h4000_0000;
          state_next = S_SIN0;
        end else begin
          mul_a      = 33'(p34 - 34'(s_whf));
          mul_b      = 33'd3;
          state_next = S_PU_MUL;
        end
      end
      S_PU_MUL: begin
        div_start  = 1'b1;
        div_num    = {prod[33:0], 30'b0};
        div_den    = 33'h1_0000_0000 - s_whf;
        kbase_c    = 34'h0_4000_0000;
        state_next = S_DIV_W;
      end
      S_DIV_W: begin
        if (div_done) state_next = knee2 ? S_KNEE : S_SIN0;
      end
      S_W4_WIN: begin
        mul_a      = 33'(p);
        mul_b      = 33'(kf);
        state_next = S_M_PK;
      end
      S_M_PK: state_next = S_SIN0;
      S_WMUL: begin
        mul_a      = 33'(ymag);
        mul_b      = 33'(winr);
        state_next = S_WMUL2;
      end
      S_WMUL2: state_next = S_FINAL;
      S_SIN0: begin
        mul_a      = 33'(sr_c);
        mul_b      = 33'(sr_c);
        state_next = S_SIN1;
      end
      S_SIN1: begin
        mul_a      = 33'(pq30);
        mul_b      = 33'(SIN_C0);
        state_next = S_SIN2;
      end
      S_SIN2: begin
        mul_a      = 33'(sr2);
        mul_b      = 33'(h_c);
        state_next = S_SIN3;
      end
      S_SIN3: begin
        mul_a      = 33'(sr2);
        mul_b      = 33'(h_c);
        state_next = S_SIN4;
      end
      S_SIN4: begin
        mul_a      = 33'(sr2);
        mul_b      = 33'(h_c);
        state_next = S_SIN5;
      end
      S_SIN5: begin
        mul_a      = 33'(sr);
        mul_b      = 33'(h_c);
        state_next = S_SIN6;
      end
      S_SIN6:  state_next = ret;
      S_FINAL: state_next = S_DONE;
      S_DONE: begin
        if (take) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          p    <= job.phase;
          a    <= job.amt;
          wave <= job.wave;
        end
      end
      S_DISPATCH: begin
        knee2 <= 1'b0;
        ret   <= S_FINAL;
        if (wave == WAVE_DSINE) begin
          sin_turn <= p + 32'h4000_0000;
          ret      <= S_W4_WIN;
        end else begin
          sin_turn <= p;
        end
        winr <= win57;
      end
      S_M_KNEE: begin
        m     <= 32'h8000_0000 - pq16;
        g     <= 34'(p);
        knee2 <= (wave == WAVE_SAWPULSE);
      end
      S_M_HF: hf <= pq16;
      S_W3_W: w <= prod[64:33];
      S_KNEE, S_SQ_SEL, S_PU_SEL, S_PU_MUL: begin
        kbase    <= kbase_c;
        sin_turn <= turn_c;
      end
      S_DIV_W: begin
        if (div_done) begin
          g        <= kbase + quot[33:0];
          sin_turn <= 32'(kbase + quot[33:0]);
          knee2    <= 1'b0;
        end
      end
      S_W4_WIN: winr <= win4[31:1];
      S_M_PK: begin
        sin_turn <= pq16;
        ret      <= S_WMUL;
      end
      S_WMUL2: y <= y[31] ? -32'(pq30) : 32'(pq30);
      S_SIN0: begin
        sr    <= sr_c;
        squad <= sin_turn[31:30];
      end
      S_SIN1: sr2 <= pq30;
      S_SIN6: y <= squad[1] ? -32'(h_end) : 32'(h_end);
      S_FINAL: sample <= y[31] ? SAMPLE_BITS'(-sat) : SAMPLE_BITS'(sat);
      default: ;
    endcase
  end

  assign stat.idle = (state == S_IDLE);
  assign stat.done = (state == S_DONE);

endmodule

### rtl/phase_distortion_oscillator.sv
`timescale 1ns / 1ps
// ============================================================================
// Phase distortion oscillator
// One oversampled sample per item from a phase remapped by a selected wave.
// ============================================================================
// Usage: each item on the item channel (restart flag) produces exactly one
// result item (sample, cycle_wrapped) on the result channel. Both channels
// use valid/ready. Configuration registers sit on an APB-style port at byte
// addresses 0x00 phase_step, 0x04 amount, 0x08 first_wave, 0x0C second_wave,
// 0x10 alternate_enable, 0x14 oversample_shift; write them only while idle.
// The phase accumulator advances as soon as an item is accepted. The sample
// is then computed by a sequencer that reuses one registered multiplier and
// one 64-step restoring divider. The plain sine, the resonant waves and the
// square and pulse plateaus do not use the divider; the double sine runs the
// sine twice. The single knee and the square and pulse ramps take one divider
// pass (the last pulse ramp after a multiply) and the double knee two passes.
// A new item can be taken in the cycle after its result leaves the sequencer.
// A finished sample moves into the output register, so a stalled receiver
// holds at most one result while the next item is computed; the sequencer
// then waits for that slot. Reset clears the phase, the wave alternation
// and the configuration registers, with the oversampling shift set to 2.
// There is no clearing pass after reset.
// ============================================================================
module phase_distortion_oscillator #(
  parameter int PHASE_BITS  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic                          restart,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          cycle_wrapped
);
  import pdo_pkg::*;

`include "phase_distortion_oscillator_macros.svh"

  localparam int UP = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
  localparam int DN = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
  localparam int WW = (PHASE_BITS > 32) ? PHASE_BITS : 32;

  // Configuration registers.
  logic [31:0] phase_step;
  logic [16:0] amount;
  logic [3:0]  first_wave;
  logic [3:0]  second_wave;
  logic        alternate_enable;
  logic [1:0]  oversample_shift;

  // Oscillator state.
  logic [PHASE_BITS-1:0] phase_accum;
  logic                  use_second;
  logic                  wrap_q;

  logic                  accept;
  logic                  cfg_wr;
  logic [PHASE_BITS-1:0] acc_eff;
  logic                  us_eff;
  logic [WW-1:0]         step_w;
  logic [WW-1:0]         inc_w;
  logic [PHASE_BITS:0]   sum;
  job_t                  job;
  seq_stat_t             stat;
  logic                  take;
  logic signed [SAMPLE_BITS-1:0] seq_sample;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;
  assign accept     = item_valid && item_ready;
  assign item_ready = stat.idle;
  assign take       = !result_valid || result_ready;

  // A restart item computes its sample from a cleared phase.
  always_comb begin
    acc_eff   = restart ? '0 : phase_accum;
    us_eff    = restart ? 1'b0 : use_second;
    job.phase = (PHASE_BITS >= 32) ? 32'(acc_eff >> UP) : (32'(acc_eff) << DN);
    job.amt   = (amount > AMOUNT_ONE) ? AMOUNT_ONE : amount;
    job.wave  = (alternate_enable && us_eff) ? second_wave : first_wave;
    step_w    = WW'(phase_step);
    inc_w     = ((step_w << UP) >> DN) >> oversample_shift;
    sum       = {1'b0, acc_eff} + {1'b0, PHASE_BITS'(inc_w)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step       <= '0;
      amount           <= '0;
      first_wave       <= '0;
      second_wave      <= '0;
      alternate_enable <= 1'b0;
      oversample_shift <= 2'd2;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_PHASE_STEP:  phase_step       <= pwdata;
        REG_AMOUNT:      amount           <= pwdata[16:0];
        REG_FIRST_WAVE:  first_wave       <= pwdata[3:0];
        REG_SECOND_WAVE: second_wave      <= pwdata[3:0];
        REG_ALT_ENABLE:  alternate_enable <= pwdata[0];
        REG_OS_SHIFT:    oversample_shift <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_PHASE_STEP:  prdata = phase_step;
      REG_AMOUNT:      prdata = 32'(amount);
      REG_FIRST_WAVE:  prdata = 32'(first_wave);
      REG_SECOND_WAVE: prdata = 32'(second_wave);
      REG_ALT_ENABLE:  prdata = 32'(alternate_enable);
      REG_OS_SHIFT:    prdata = 32'(oversample_shift);
      default:         prdata = '0;
    endcase
  end

  // The phase moves on at accept time; the wrap flag waits for its sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_accum <= '0;
      use_second  <= 1'b0;
    end else if (accept) begin
      phase_accum <= sum[PHASE_BITS-1:0];
      use_second  <= us_eff ^ (sum[PHASE_BITS] && alternate_enable);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) wrap_q <= sum[PHASE_BITS];
  end

  pdo_seq #(.SAMPLE_BITS(SAMPLE_BITS)) u_seq (
    .clk(clk), .rst(rst), .start(accept), .job(job), .take(take),
    .stat(stat), .sample(seq_sample)
  );

  // Output register between the sequencer and the receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (stat.done && take) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done && take) begin
      sample        <= seq_sample;
      cycle_wrapped <= wrap_q;
    end
  end

  // An accepted item keeps the sequencer busy for at least the next cycle.
  `PDO_ASSERT_NXT(a_busy_after_accept, clk, rst, accept, !item_ready)
  // A finished sample that is handed over is visible on the next cycle.
  `PDO_ASSERT_NXT(a_handover, clk, rst, stat.done && take, result_valid)
  // Without alternation and restart the wave selection never changes.
  `PDO_ASSERT_NXT(a_alt_hold, clk, rst, accept && !alternate_enable && !restart,
                  $stable(use_second))
  // The sequencer is never idle and done at once.
  `PDO_ASSERT_IMP(a_stat_excl, clk, rst, stat.done, !stat.idle)

endmodule
